// ----- hdl/ptg_pkg.sv -----
package ptg_pkg;

  localparam int unsigned CLOCK_W = 27;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CMP_W   = 15;
  localparam int unsigned OP_W    = 2;

  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd48000000;
  localparam logic [15:0]        PERIOD_LIMIT   = 16'd65535;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd20;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd20000;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd100;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2
  } op_e;

endpackage

// ----- hdl/ptg_cfg_if.sv -----
interface ptg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ptg_pkg::CLOCK_W-1:0]    clock_hz;

  modport source (output valid, output clock_hz, input ready);
  modport sink   (input valid, input clock_hz, output ready);
endinterface

// ----- hdl/ptg_item_if.sv -----
interface ptg_item_if;
  logic                        valid;
  logic                        ready;
  logic [ptg_pkg::OP_W-1:0]    op;
  logic [ptg_pkg::FREQ_W-1:0]  freq_hz;
  logic [ptg_pkg::DUTY_W-1:0]  duty_percent;

  modport source (output valid, output op, output freq_hz, output duty_percent, input ready);
  modport sink   (input valid, input op, input freq_hz, input duty_percent, output ready);
endinterface

// ----- hdl/ptg_result_if.sv -----
interface ptg_result_if;
  logic                         valid;
  logic                         ready;
  logic                         tone_out;
  logic                         is_playing;
  logic [ptg_pkg::VALUE_W-1:0]  prescale_value;
  logic [ptg_pkg::VALUE_W-1:0]  period_value;
  logic [ptg_pkg::CMP_W-1:0]    compare_value;

  modport source (output valid, output tone_out, output is_playing, output prescale_value,
                  output period_value, output compare_value, input ready);
  modport sink   (input valid, input tone_out, input is_playing, input prescale_value,
                  input period_value, input compare_value, output ready);
endinterface

// ----- hdl/pwm_tone_generator.sv -----
// Tick, stop and idle codes: result valid the cycle after accept;
// back-to-back beats are taken while the result slot is free or being drained.
// Play: the result is computed by one shared multiplier, a one-bit-per-cycle
// restoring divider (27 steps) used twice and a reciprocal multiply for the divide by 100.
// Reset (rst_ni low, asynchronous): stopped, counters and timer values zero,
// clock_hz back to 48 MHz, no result pending.
module pwm_tone_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptg_cfg_if.sink       cfg_i,
  ptg_item_if.sink      item_i,
  ptg_result_if.source  result_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take beats
  localparam logic [2:0] S_MUL  = 3'd1;  // register one product, load divider or high-time product
  localparam logic [2:0] S_DIV  = 3'd2;  // one quotient bit per cycle
  localparam logic [2:0] S_NEXT = 3'd3;  // use quotient, set up next phase
  localparam logic [2:0] S_FIN  = 3'd4;  // commit settings when result slot frees

  // Phases of the play computation
  localparam logic [1:0] PH_DIV = 2'd0;  // divider = clk / (limit * f) + 1
  localparam logic [1:0] PH_APR = 2'd1;  // apr = clk / (divider * f)
  localparam logic [1:0] PH_CMP = 2'd2;  // cmp = (apr / 2) * duty / 100

  localparam int unsigned NUM_W = ptg_pkg::CLOCK_W;
  localparam int unsigned DEN_W = 31;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned VW    = ptg_pkg::VALUE_W;
  localparam int unsigned CW    = ptg_pkg::CMP_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  // Divide by 100 as a multiply by ceil(2^29 / 100); exact for products below 2^22
  localparam int unsigned SCALED_W    = 22;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned PROD_W      = SCALED_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

  logic [2:0]                     state_q, state_d;
  logic [1:0]                     phase_q, phase_d;
  logic [ptg_pkg::CLOCK_W-1:0]    clock_hz_q, clock_hz_d;
  logic                           res_valid_q, res_valid_d;

  // Timer state
  logic                           running_q, running_d;
  logic [VW-1:0]                  pre_cnt_q, pre_cnt_d;
  logic [VW-1:0]                  per_cnt_q, per_cnt_d;
  logic [VW-1:0]                  act_pre_q, act_pre_d;
  logic [VW-1:0]                  act_per_q, act_per_d;
  logic [CW-1:0]                  act_cmp_q, act_cmp_d;
  logic [VW-1:0]                  pend_pre_q, pend_pre_d;
  logic [VW-1:0]                  pend_per_q, pend_per_d;
  logic [CW-1:0]                  pend_cmp_q, pend_cmp_d;

  // Datapath of the shared unit
  logic [14:0]                    freq_q, freq_d;
  logic [6:0]                     duty_q, duty_d;
  logic [15:0]                    mul_a_q, mul_a_d;
  logic [14:0]                    mul_b_q, mul_b_d;
  logic [NUM_W-1:0]               num_q, num_d;
  logic [NUM_W-1:0]               rem_q, rem_d;
  logic [DEN_W-1:0]               den_q, den_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [VW-1:0]                  calc_pre_q, calc_pre_d;
  logic [VW-1:0]                  calc_per_q, calc_per_d;
  logic [CW-1:0]                  calc_cmp_q, calc_cmp_d;

  logic                           slot_free;
  logic                           item_fire;
  logic [DEN_W-1:0]               product;
  logic [NUM_W:0]                 shifted;
  logic [DEN_W:0]                 diff;
  logic                           quo_bit;
  logic [PROD_W-1:0]              scaled;
  logic [PROD_W-RECIP_SHIFT-1:0]  cmp_quo;
  logic [ptg_pkg::FREQ_W-1:0]     freq_clamp;
  logic [ptg_pkg::DUTY_W-1:0]     duty_clamp;
  logic [VW-1:0]                  apr;

  // The result slot frees when empty or drained this cycle
  assign slot_free  = !res_valid_q || result_o.ready;
  assign item_i.ready = (state_q == S_IDLE) && slot_free;
  assign item_fire  = item_i.valid && item_i.ready;
  assign cfg_i.ready = 1'b1;

  // Result fields follow the timer state; it only moves when a result is loaded
  assign result_o.valid          = res_valid_q;
  assign result_o.tone_out       = running_q && ({1'b0, per_cnt_q} < {2'b0, act_cmp_q});
  assign result_o.is_playing     = running_q;
  assign result_o.prescale_value = pend_pre_q;
  assign result_o.period_value   = pend_per_q;
  assign result_o.compare_value  = pend_cmp_q;

  // Shared multiplier and one restoring-divide step
  assign product = DEN_W'(mul_a_q) * DEN_W'(mul_b_q);
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = {{(DEN_W - NUM_W){1'b0}}, shifted} - {1'b0, den_q};
  assign quo_bit = !diff[DEN_W];

  // High-time product divided by 100
  assign scaled  = PROD_W'(num_q[SCALED_W-1:0]) * PROD_W'(RECIP_100);
  assign cmp_quo = scaled[PROD_W-1:RECIP_SHIFT];

  // Clamp play operands
  always_comb begin
    if (item_i.freq_hz < ptg_pkg::FREQ_MIN) begin
      freq_clamp = ptg_pkg::FREQ_MIN;
    end else if (item_i.freq_hz > ptg_pkg::FREQ_MAX) begin
      freq_clamp = ptg_pkg::FREQ_MAX;
    end else begin
      freq_clamp = item_i.freq_hz;
    end
    if (item_i.duty_percent > ptg_pkg::DUTY_MAX) begin
      duty_clamp = ptg_pkg::DUTY_MAX;
    end else begin
      duty_clamp = item_i.duty_percent;
    end
  end

  // Period count, never zero
  assign apr = (num_q == '0) ? VW'(1) : num_q[VW-1:0];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clock_hz_d  = clock_hz_q;
    res_valid_d = res_valid_q && !result_o.ready;
    running_d   = running_q;
    pre_cnt_d   = pre_cnt_q;
    per_cnt_d   = per_cnt_q;
    act_pre_d   = act_pre_q;
    act_per_d   = act_per_q;
    act_cmp_d   = act_cmp_q;
    pend_pre_d  = pend_pre_q;
    pend_per_d  = pend_per_q;
    pend_cmp_d  = pend_cmp_q;
    freq_d      = freq_q;
    duty_d      = duty_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    num_d       = num_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    calc_pre_d  = calc_pre_q;
    calc_per_d  = calc_per_q;
    calc_cmp_d  = calc_cmp_q;

    if (cfg_i.valid && cfg_i.ready) begin
      clock_hz_d = cfg_i.clock_hz;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_fire) begin
          case (item_i.op)
            ptg_pkg::OP_TICK: begin
              res_valid_d = 1'b1;
              if (running_q) begin
                if (pre_cnt_q >= act_pre_q) begin
                  pre_cnt_d = '0;
                  // Period wrap: load held settings
                  if (per_cnt_q >= act_per_q) begin
                    per_cnt_d = '0;
                    act_pre_d = pend_pre_q;
                    act_per_d = pend_per_q;
                    act_cmp_d = pend_cmp_q;
                  end else begin
                    per_cnt_d = per_cnt_q + VW'(1);
                  end
                end else begin
                  pre_cnt_d = pre_cnt_q + VW'(1);
                end
              end
            end
            ptg_pkg::OP_PLAY: begin
              freq_d  = freq_clamp[14:0];
              duty_d  = duty_clamp[6:0];
              mul_a_d = ptg_pkg::PERIOD_LIMIT;
              mul_b_d = freq_clamp[14:0];
              phase_d = PH_DIV;
              state_d = S_MUL;
            end
            ptg_pkg::OP_STOP: begin
              running_d   = 1'b0;
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        rem_d = '0;
        cnt_d = '0;
        if (phase_q == PH_CMP) begin
          num_d   = product[NUM_W-1:0];
          state_d = S_NEXT;
        end else begin
          num_d   = clock_hz_q;
          den_d   = product;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = quo_bit ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
        num_d = {num_q[NUM_W-2:0], quo_bit};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        unique case (phase_q)
          PH_DIV: begin
            calc_pre_d = num_q[VW-1:0];
            mul_a_d    = num_q[VW-1:0] + VW'(1);
            mul_b_d    = freq_q;
            phase_d    = PH_APR;
            state_d    = S_MUL;
          end
          PH_APR: begin
            calc_per_d = apr - VW'(1);
            mul_a_d    = {1'b0, apr[VW-1:1]};
            mul_b_d    = {8'b0, duty_q};
            phase_d    = PH_CMP;
            state_d    = S_MUL;
          end
          default: begin
            calc_cmp_d = (cmp_quo == '0) ? CW'(1) : cmp_quo[CW-1:0];
            state_d    = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        // Hold until the previous result is gone, then commit
        if (slot_free) begin
          pend_pre_d  = calc_pre_q;
          pend_per_d  = calc_per_q;
          pend_cmp_d  = calc_cmp_q;
          if (!running_q) begin
            act_pre_d = calc_pre_q;
            act_per_d = calc_per_q;
            act_cmp_d = calc_cmp_q;
            pre_cnt_d = '0;
            per_cnt_d = '0;
            running_d = 1'b1;
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_DIV;
      clock_hz_q  <= ptg_pkg::CLOCK_HZ_RESET;
      res_valid_q <= 1'b0;
      running_q   <= 1'b0;
      pre_cnt_q   <= '0;
      per_cnt_q   <= '0;
      act_pre_q   <= '0;
      act_per_q   <= '0;
      act_cmp_q   <= '0;
      pend_pre_q  <= '0;
      pend_per_q  <= '0;
      pend_cmp_q  <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clock_hz_q  <= clock_hz_d;
      res_valid_q <= res_valid_d;
      running_q   <= running_d;
      pre_cnt_q   <= pre_cnt_d;
      per_cnt_q   <= per_cnt_d;
      act_pre_q   <= act_pre_d;
      act_per_q   <= act_per_d;
      act_cmp_q   <= act_cmp_d;
      pend_pre_q  <= pend_pre_d;
      pend_per_q  <= pend_per_d;
      pend_cmp_q  <= pend_cmp_d;
    end
  end

  // Arithmetic datapath, no reset needed
  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    duty_q     <= duty_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    cnt_q      <= cnt_d;
    calc_pre_q <= calc_pre_d;
    calc_per_q <= calc_per_d;
    calc_cmp_q <= calc_cmp_d;
  end

`ifndef NO_ASSERTIONS
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready |-> (state_q == S_IDLE))
    else $error("item ready outside idle");

  a_tone_needs_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.tone_out |-> result_o.is_playing)
    else $error("tone high while stopped");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pre_cnt_q <= act_pre_q) && (per_cnt_q <= act_per_q))
    else $error("timer count beyond active limit");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ({{(DEN_W - NUM_W){1'b0}}, rem_q} < den_q))
    else $error("divider remainder not below divisor");
`endif

endmodule
